// ===== design/ybgr_pkg.sv =====
`timescale 1ns / 1ps
// ybgr_pkg: fixed-point constants, chroma offset type and 8-bit clamp
// shared by the YCbCr to BGR converter. No dependencies.
package ybgr_pkg;

  localparam int PROD_W  = 27;
  localparam int DELTA_W = 10;
  localparam int SUM_W   = 11;
  localparam int SCALE   = 16;

  localparam logic signed [PROD_W-1:0] K_CR_R   = 27'sd91881;
  localparam logic signed [PROD_W-1:0] K_CB_B   = 27'sd116130;
  localparam logic signed [PROD_W-1:0] K_CB_G   = 27'sd22554;
  localparam logic signed [PROD_W-1:0] K_CR_G   = 27'sd46802;
  localparam logic signed [PROD_W-1:0] HALF_LSB = 27'sd32768;

  localparam logic [7:0] CHROMA_MID = 8'd128;
  localparam logic [7:0] PIX_MAX    = 8'hff;

  typedef struct packed {
    logic signed [DELTA_W-1:0] red;
    logic signed [DELTA_W-1:0] green;
    logic signed [DELTA_W-1:0] blue;
  } chroma_delta_t;

  function automatic logic [7:0] sat8(input logic signed [SUM_W-1:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > $signed({3'b000, PIX_MAX})) begin
      res = PIX_MAX;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

// ===== design/ybgr_chroma_offsets.sv =====
`timescale 1ns / 1ps
// ybgr_chroma_offsets: centers Cb/Cr and forms the rounded red, green and
// blue offsets in 16-bit fixed point. Uses ybgr_pkg.
module ybgr_chroma_offsets (
  input  logic [7:0]                   cb,
  input  logic [7:0]                   cr,
  output ybgr_pkg::chroma_delta_t      delta
);
  import ybgr_pkg::*;

  logic signed [8:0]        cb_c;
  logic signed [8:0]        cr_c;
  logic signed [PROD_W-1:0] sum_r;
  logic signed [PROD_W-1:0] sum_g;
  logic signed [PROD_W-1:0] sum_b;

  assign cb_c = $signed({1'b0, cb}) - $signed({1'b0, CHROMA_MID});
  assign cr_c = $signed({1'b0, cr}) - $signed({1'b0, CHROMA_MID});

  assign sum_r = K_CR_R * cr_c + HALF_LSB;
  assign sum_b = K_CB_B * cb_c + HALF_LSB;
  assign sum_g = HALF_LSB - K_CB_G * cb_c - K_CR_G * cr_c;

  // floor shift: the upper bits of the two's complement sum
  assign delta.red   = sum_r[SCALE+DELTA_W-1:SCALE];
  assign delta.green = sum_g[SCALE+DELTA_W-1:SCALE];
  assign delta.blue  = sum_b[SCALE+DELTA_W-1:SCALE];

endmodule

// ===== design/ycbcr_to_bgr_convert_unit.sv =====
`timescale 1ns / 1ps
// ycbcr_to_bgr_convert_unit: top level, YCbCr (single or 4:2:2 pair) to
// saturated 8-bit RGB. Uses ybgr_pkg and ybgr_chroma_offsets.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | start / busy       | luma_first, luma_second, chroma_*, row_end
//  out     | out_valid strobe   | red/green/blue _first/_second, row_end_out
//  cfg     | cfg_we             | cfg_wdata (pair_mode)
//
// One beat per clock in, one beat per clock out; busy is always low.
// The path runs through the input register, then offset multiply, add and
// clamp into the result register.
// Reset (rst_n low, synchronous) clears pair_mode and the valid flags.
// The receiver cannot stall; each result is shown for exactly one cycle.
module ycbcr_to_bgr_convert_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_luma_first,
  input  logic [7:0] in_luma_second,
  input  logic [7:0] in_chroma_blue,
  input  logic [7:0] in_chroma_red,
  input  logic       in_row_end,
  output logic       out_valid,
  output logic [7:0] out_red_first,
  output logic [7:0] out_green_first,
  output logic [7:0] out_blue_first,
  output logic [7:0] out_red_second,
  output logic [7:0] out_green_second,
  output logic [7:0] out_blue_second,
  output logic       out_row_end_out,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import ybgr_pkg::*;

  logic          pair_mode_r;
  logic          in_vld_r;
  logic [7:0]    y1_r;
  logic [7:0]    y2_r;
  logic [7:0]    cb_r;
  logic [7:0]    cr_r;
  logic          row_end_r;
  chroma_delta_t delta;

  logic          out_vld_r;
  logic [7:0]    r1_r, g1_r, b1_r, r2_r, g2_r, b2_r;
  logic          row_end_out_r;
  logic [7:0]    r1_nxt, g1_nxt, b1_nxt, r2_nxt, g2_nxt, b2_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_mode_r <= 1'b0;
    end else if (cfg_we) begin
      pair_mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      y1_r      <= in_luma_first;
      y2_r      <= in_luma_second;
      cb_r      <= in_chroma_blue;
      cr_r      <= in_chroma_red;
      row_end_r <= in_row_end;
    end
  end

  ybgr_chroma_offsets u_offsets (
    .cb    (cb_r),
    .cr    (cr_r),
    .delta (delta)
  );

  always_comb begin
    r1_nxt = sat8($signed({3'b000, y1_r}) + SUM_W'(delta.red));
    g1_nxt = sat8($signed({3'b000, y1_r}) + SUM_W'(delta.green));
    b1_nxt = sat8($signed({3'b000, y1_r}) + SUM_W'(delta.blue));
    if (pair_mode_r) begin
      r2_nxt = sat8($signed({3'b000, y2_r}) + SUM_W'(delta.red));
      g2_nxt = sat8($signed({3'b000, y2_r}) + SUM_W'(delta.green));
      b2_nxt = sat8($signed({3'b000, y2_r}) + SUM_W'(delta.blue));
    end else begin
      r2_nxt = 8'd0;
      g2_nxt = 8'd0;
      b2_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      r1_r          <= r1_nxt;
      g1_r          <= g1_nxt;
      b1_r          <= b1_nxt;
      r2_r          <= r2_nxt;
      g2_r          <= g2_nxt;
      b2_r          <= b2_nxt;
      row_end_out_r <= row_end_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_red_first    = r1_r;
  assign out_green_first  = g1_r;
  assign out_blue_first   = b1_r;
  assign out_red_second   = r2_r;
  assign out_green_second = g2_r;
  assign out_blue_second  = b2_r;
  assign out_row_end_out  = row_end_out_r;

  a_beat_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted beat did not produce a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without an accepted beat");

  a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !pair_mode_r) |->
      (out_red_second == 8'd0 && out_green_second == 8'd0 && out_blue_second == 8'd0))
    else $error("second pixel not zero in single mode");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_end_out == $past(in_row_end, 2)))
    else $error("row end flag not carried with its beat");

endmodule
